FILE: src/fixed_weight_ternary_sampler_macros.svh
// Assertion macros used by the sampler RTL (fwts_back).
// Needs nothing; include inside a module body.
`ifndef FIXED_WEIGHT_TERNARY_SAMPLER_MACROS_SVH
`define FIXED_WEIGHT_TERNARY_SAMPLER_MACROS_SVH

// Same-cycle implication.
`define FWTS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FWTS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/fwts_pkg.sv
// Types and constants of the fixed-weight ternary sampler.
// No dependencies; used by every module of the block.
package fwts_pkg;

   localparam int MAX_N   = 1024;
   localparam int IDX_W   = $clog2(MAX_N);
   localparam int N_W     = 11;
   localparam int K_W     = 10;
   localparam int POS_W   = 10;
   localparam int SIGN_W  = 2;
   localparam int VAL_W   = 16;
   localparam int BYTE_W  = 8;
   localparam int EPOCH_W = 8;
   localparam int CSR_W   = 11;
   localparam int CSR_IW  = 1;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);

   localparam logic [CSR_IW-1:0] REG_LENGTH_N = 1'd0;
   localparam logic [CSR_IW-1:0] REG_WEIGHT_K = 1'd1;

   localparam logic [N_W-1:0] LENGTH_N_RST = 11'd512;
   localparam logic [K_W-1:0] WEIGHT_K_RST = 10'd64;

   localparam logic [SIGN_W-1:0] SIGN_POS = 2'b01;
   localparam logic [SIGN_W-1:0] SIGN_NEG = 2'b11;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_PICK = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   typedef struct packed {
      logic [1:0]       kind;
      logic             start;
      logic [VAL_W-1:0] value;
      logic             wide;
      logic [IDX_W-1:0] idx;
      logic [N_W-1:0]   range;
      logic             neg1;
      logic             last1;
      logic             dbl;
      logic             neg2;
      logic             last2;
   } cmd_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [IDX_W-1:0]   val;
   } entry_type;

endpackage

FILE: src/fixed_weight_ternary_sampler.sv
// Path of a byte that completes a pick: pop, dispatch, remainder unit over one gathered
// byte or two, read, two writes, load of the result register.
// Intake: one byte beat per cycle into a 4-deep command queue while the queue is not full
// and no memory clear runs; the back end takes one command at a time: non-pick start
// beats, error beats and picks, where a pick whose next place has range 1 emits it too.
// Reset: synchronous; memory clear of 1024 entries with req_tready low, repeated every 255th start.
module fixed_weight_ternary_sampler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [fwts_pkg::CSR_IW-1:0] csr_index,
   input  logic [fwts_pkg::CSR_W-1:0]  csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,  // data_byte
   input  logic                        req_tuser,  // action
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,  // position[9:0], sign[11:10], zero pad
   output logic                        rsp_tlast,  // last
   output logic                        rsp_tuser   // error
);
   import fwts_pkg::*;

   cmd_type q_data;
   cmd_type q_head;
   logic    q_push;
   logic    q_pop;
   logic    q_empty;
   logic    q_full;
   logic    clear_busy;

   fwts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .clear_busy (clear_busy),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   fwts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   fwts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: src/fwts_queue.sv
// Command queue between front and back of the sampler.
// Depends on fwts_pkg (cmd_type, QDEPTH).
module fwts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fwts_pkg::cmd_type push_data,
   input  logic              pop,
   output fwts_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);
   import fwts_pkg::*;

   cmd_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign head  = slot_ff[rd_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (QPTR_W+1)'(QDEPTH));

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: src/fwts_front.sv
// Front end: config registers, byte gathering and pick bookkeeping.
// Depends on fwts_pkg; emits one command per beat that needs back-end work.
module fwts_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [fwts_pkg::CSR_IW-1:0] csr_index,
   input  logic [fwts_pkg::CSR_W-1:0]  csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fwts_pkg::BYTE_W-1:0] req_tdata,
   input  logic                        req_tuser,
   input  logic                        q_full,
   input  logic                        clear_busy,
   output logic                        q_push,
   output fwts_pkg::cmd_type           q_data
);
   import fwts_pkg::*;

   logic [N_W-1:0]    n_ff;
   logic [K_W-1:0]    k_ff;
   logic [N_W-1:0]    pc_ff, pc_in;
   logic              have_ff, have_in;
   logic [BYTE_W-1:0] lo_ff, lo_in;

   logic           accept;
   logic [N_W-1:0] pc_e;
   logic           have_e;
   logic [N_W-1:0] total;
   logic           bad;
   logic [N_W-1:0] range;
   logic [N_W-1:0] span;
   logic           take;
   logic [N_W-1:0] pc1;
   logic [N_W-1:0] pc2;
   logic           dbl;

   assign req_tready = !q_full && !clear_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pc_e   = req_tuser ? '0 : pc_ff;
      have_e = req_tuser ? 1'b0 : have_ff;
      total  = {k_ff, 1'b0};
      bad    = (total > n_ff) || ({1'b0, n_ff} > (N_W+1)'(MAX_N));
      range  = n_ff - pc_e;
      span   = range - 1'b1;
      take   = have_e || (span[N_W-1:BYTE_W] == '0);
      pc1    = pc_e + 1'b1;
      pc2    = pc_e + 2'd2;
      dbl    = (pc1 < total) && ((n_ff - pc1) == N_W'(1));

      q_data.kind  = KIND_NONE;
      q_data.start = req_tuser;
      q_data.value = have_e ? {req_tdata, lo_ff} : {{(VAL_W-BYTE_W){1'b0}}, req_tdata};
      q_data.wide  = have_e;
      q_data.idx   = pc_e[IDX_W-1:0];
      q_data.range = range;
      q_data.neg1  = !(pc_e < {1'b0, k_ff});
      q_data.last1 = (pc1 == total);
      q_data.dbl   = dbl;
      q_data.neg2  = !(pc1 < {1'b0, k_ff});
      q_data.last2 = (pc2 == total);

      q_push  = 1'b0;
      pc_in   = pc_ff;
      have_in = have_ff;
      lo_in   = lo_ff;

      if (accept) begin
         pc_in   = pc_e;
         have_in = have_e;
         if (bad) begin
            q_push      = 1'b1;
            q_data.kind = KIND_ERR;
         end else if (pc_e >= total) begin
            q_push = req_tuser;
         end else if (take) begin
            q_push      = 1'b1;
            q_data.kind = KIND_PICK;
            pc_in       = dbl ? pc2 : pc1;
            have_in     = 1'b0;
         end else begin
            q_push  = req_tuser;
            have_in = 1'b1;
            lo_in   = req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= LENGTH_N_RST;
         k_ff    <= WEIGHT_K_RST;
         pc_ff   <= '0;
         have_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         have_ff <= have_in;
         if (csr_we) begin
            case (csr_index)
               REG_LENGTH_N: begin
                  n_ff <= csr_wdata[N_W-1:0];
               end
               REG_WEIGHT_K: begin
                  k_ff <= csr_wdata[K_W-1:0];
               end
               default: begin
                  n_ff <= n_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
   end

endmodule

FILE: src/fwts_back.sv
// Back end: radix-4 remainder unit, permutation memory with epoch tags, result register.
// Depends on fwts_pkg and the assertion macro header.
module fwts_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  fwts_pkg::cmd_type           q_head,
   output logic                        q_pop,
   output logic                        clear_busy,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);
   import fwts_pkg::*;
   `include "fixed_weight_ternary_sampler_macros.svh"

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DISP  = 4'd2;
   localparam logic [3:0] S_DIV   = 4'd3;
   localparam logic [3:0] S_READ  = 4'd4;
   localparam logic [3:0] S_WR_I  = 4'd5;
   localparam logic [3:0] S_WR_J  = 4'd6;
   localparam logic [3:0] S_EMIT1 = 4'd7;
   localparam logic [3:0] S_READ2 = 4'd8;
   localparam logic [3:0] S_EMIT2 = 4'd9;
   localparam logic [3:0] S_ERR   = 4'd10;

   localparam int DW = N_W + 1;

   entry_type mem [MAX_N];

   logic [3:0]         state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic               pend_ff, pend_in;
   logic [VAL_W-1:0]   shift_ff, shift_in;
   logic [N_W-1:0]     rem_ff, rem_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [IDX_W-1:0]   vi_ff, vi_in;
   logic [IDX_W-1:0]   vj_ff, vj_in;
   entry_type          rd_a_ff, rd_b_ff;

   logic               out_valid_ff, out_valid_in;
   logic [15:0]        out_data_ff, out_data_in;
   logic               out_last_ff, out_last_in;
   logic               out_err_ff, out_err_in;

   logic               out_free;
   logic               out_load;
   logic [DW-1:0]      t1, r1, t2, r2;
   logic [IDX_W-1:0]   idx_n;
   logic [IDX_W-1:0]   addr_a;
   logic [IDX_W-1:0]   addr_j;
   logic [IDX_W-1:0]   va, vb;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   entry_type          mem_wd;

   assign clear_busy = (state_ff == S_CLEAR);
   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

   // Two quotient bits per cycle.
   always_comb begin
      t1 = {rem_ff, shift_ff[VAL_W-1]};
      r1 = (t1 >= {1'b0, cmd_ff.range}) ? t1 - {1'b0, cmd_ff.range} : t1;
      t2 = {r1[N_W-1:0], shift_ff[VAL_W-2]};
      r2 = (t2 >= {1'b0, cmd_ff.range}) ? t2 - {1'b0, cmd_ff.range} : t2;
   end

   always_comb begin
      idx_n  = cmd_ff.idx + 1'b1;
      addr_a = (state_ff == S_READ2 || state_ff == S_EMIT2) ? idx_n : cmd_ff.idx;
      addr_j = cmd_ff.idx + rem_ff[IDX_W-1:0];
      va     = (rd_a_ff.tag == epoch_ff) ? rd_a_ff.val : addr_a;
      vb     = (rd_b_ff.tag == epoch_ff) ? rd_b_ff.val : addr_j;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      epoch_in     = epoch_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      vi_in        = vi_ff;
      vj_in        = vj_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = cmd_ff.idx;
      mem_wd       = '0;
      out_load     = 1'b0;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(MAX_N - 1)) begin
               epoch_in = EPOCH_W'(1);
               pend_in  = 1'b0;
               state_in = pend_ff ? S_DISP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               state_in = S_DISP;
               if (q_head.start) begin
                  if (epoch_ff == '1) begin
                     clr_in   = '0;
                     pend_in  = 1'b1;
                     state_in = S_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         S_DISP: begin
            shift_in = cmd_ff.wide ? cmd_ff.value
                                   : {cmd_ff.value[BYTE_W-1:0], {BYTE_W{1'b0}}};
            rem_in   = '0;
            cnt_in   = cmd_ff.wide ? 3'd7 : 3'd3;
            case (cmd_ff.kind)
               KIND_PICK: begin
                  state_in = S_DIV;
               end
               KIND_ERR: begin
                  state_in = S_ERR;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DIV: begin
            rem_in   = r2[N_W-1:0];
            shift_in = {shift_ff[VAL_W-3:0], 2'b00};
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_WR_I;
         end
         S_WR_I: begin
            mem_we   = 1'b1;
            mem_wa   = cmd_ff.idx;
            mem_wd   = '{tag: epoch_ff, val: vb};
            vi_in    = va;
            vj_in    = vb;
            state_in = S_WR_J;
         end
         S_WR_J: begin
            mem_we   = 1'b1;
            mem_wa   = addr_j;
            mem_wd   = '{tag: epoch_ff, val: vi_ff};
            state_in = S_EMIT1;
         end
         S_EMIT1: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_data_in = {{(16-POS_W-SIGN_W){1'b0}},
                              cmd_ff.neg1 ? SIGN_NEG : SIGN_POS,
                              POS_W'(vj_ff)};
               out_last_in = cmd_ff.last1;
               out_err_in  = 1'b0;
               state_in    = cmd_ff.dbl ? S_READ2 : S_IDLE;
            end
         end
         S_READ2: begin
            state_in = S_EMIT2;
         end
         S_EMIT2: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_data_in = {{(16-POS_W-SIGN_W){1'b0}},
                              cmd_ff.neg2 ? SIGN_NEG : SIGN_POS,
                              POS_W'(va)};
               out_last_in = cmd_ff.last2;
               out_err_in  = 1'b0;
               state_in    = S_IDLE;
            end
         end
         S_ERR: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_data_in = '0;
               out_last_in = 1'b0;
               out_err_in  = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         epoch_ff     <= EPOCH_W'(1);
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      shift_ff    <= shift_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      vi_ff       <= vi_in;
      vj_ff       <= vj_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   // Permutation memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_j];
   end

   `FWTS_ASSERT_IMP(a_rem_in_range, clock, reset, state_ff == S_READ,
                    rem_ff < cmd_ff.range, "remainder not below range")
   `FWTS_ASSERT_IMP(a_epoch_live, clock, reset, 1'b1, epoch_ff != '0,
                    "epoch collides with cleared tag")
   `FWTS_ASSERT_IMP(a_quiet_clear, clock, reset, state_ff == S_CLEAR, !out_load && !q_pop,
                    "activity during memory clear")
   `FWTS_ASSERT_NXT(a_swap_pair, clock, reset, state_ff == S_WR_I, state_ff == S_WR_J,
                    "swap split")

endmodule
